/* hdl/cfci_pkg.sv */
// Shared types and constants for the credit flow control input port.
`timescale 1ns / 1ps
`default_nettype none
package cfci_pkg;

  // Default credit ceiling
  localparam int MAX_CREDITS_DEF = 255;

  // Field widths
  localparam int CMD_W     = 2;
  localparam int PAYLOAD_W = 32;
  localparam int ID_W      = 16;
  localparam int KIND_W    = 3;
  localparam int COUNT_W   = 8;

  // Input command codes
  localparam logic [CMD_W-1:0] CMD_ARRIVE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CONSUME = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SLOT    = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_NONE   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_DATA   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_CREDIT = 3'd2;
  localparam logic [KIND_W-1:0] KIND_NACK   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REFUSE = 3'd4;
  localparam logic [KIND_W-1:0] KIND_MISRT  = 3'd5;

  // Classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_NOP,
    OP_DATA,
    OP_MISROUTE,
    OP_CLAIM,
    OP_DISCONNECT,
    OP_CONSUME,
    OP_SLOT
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [PAYLOAD_W-1:0] payload;
  } req_t;

  typedef struct packed {
    logic [KIND_W-1:0]    kind;
    logic [PAYLOAD_W-1:0] data;
    logic [ID_W-1:0]      comp;
    logic [ID_W-1:0]      chan;
    logic [COUNT_W-1:0]   count;
  } res_t;

endpackage
`default_nettype wire

/* hdl/cfci_front.sv */
// Front end: holds sink_id and classifies each incoming request.
`timescale 1ns / 1ps
`default_nettype none
module cfci_front (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [cfci_pkg::ID_W-1:0]      cfg_wr_data,
  input  wire logic [cfci_pkg::CMD_W-1:0]     cmd,
  input  wire logic [cfci_pkg::PAYLOAD_W-1:0] payload,
  input  wire logic [cfci_pkg::ID_W-1:0]      dest_id,
  input  wire logic                           multicast,
  input  wire logic                           allocate,
  input  wire logic                           acquired,
  output cfci_pkg::req_t                      req
);

  logic [cfci_pkg::ID_W-1:0] sink_id_r;

  // Config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sink_id_r <= '0;
    end else if (cfg_wr_en) begin
      sink_id_r <= cfg_wr_data;
    end
  end

  // Decode; pending nack/disconnect is checked in the back end
  always_comb begin
    req.payload = payload;
    case (cmd)
      cfci_pkg::CMD_ARRIVE: begin
        if (!multicast && (dest_id != sink_id_r)) begin
          req.op = cfci_pkg::OP_MISROUTE;
        end else if (!allocate) begin
          req.op = cfci_pkg::OP_DATA;
        end else if (acquired) begin
          req.op = cfci_pkg::OP_DISCONNECT;
        end else begin
          req.op = cfci_pkg::OP_CLAIM;
        end
      end
      cfci_pkg::CMD_CONSUME: req.op = cfci_pkg::OP_CONSUME;
      cfci_pkg::CMD_SLOT:    req.op = cfci_pkg::OP_SLOT;
      default:               req.op = cfci_pkg::OP_NOP;
    endcase
  end

endmodule
`default_nettype wire

/* hdl/cfci_queue.sv */
// Two-entry request queue between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module cfci_queue (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  push,
  input  wire cfci_pkg::req_t push_req,
  output logic       full,
  input  wire logic  pop,
  output logic       head_valid,
  output cfci_pkg::req_t head_req
);

  localparam int DEPTH = 2;

  cfci_pkg::req_t entry_r [DEPTH];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;
  logic           do_push, do_pop;

  assign full       = (count_r == 2'(DEPTH));
  assign head_valid = (count_r != 2'd0);
  assign head_req   = entry_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_req;
    end
  end

endmodule
`default_nettype wire

/* hdl/cfci_back.sv */
// Back end: connection state, credit counting and the result register.
`timescale 1ns / 1ps
`default_nettype none
module cfci_back #(
  parameter int MAX_CREDITS = cfci_pkg::MAX_CREDITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     req_valid,
  input  wire cfci_pkg::req_t req,
  output logic          req_take,
  output logic          out_valid,
  input  wire logic     out_stall,
  output cfci_pkg::res_t res
);

  localparam int CAP_INT = (MAX_CREDITS < 255) ? MAX_CREDITS : 255;
  localparam logic [cfci_pkg::COUNT_W-1:0] CAP = CAP_INT[cfci_pkg::COUNT_W-1:0];
  localparam logic [cfci_pkg::COUNT_W-1:0] CNT_ONE = {{(cfci_pkg::COUNT_W-1){1'b0}}, 1'b1};
  localparam int IW = cfci_pkg::ID_W;

  logic                          src_valid_r, src_valid_nxt;
  logic [IW-1:0]                 src_comp_r, src_comp_nxt;
  logic [IW-1:0]                 src_chan_r, src_chan_nxt;
  logic                          nack_valid_r, nack_valid_nxt;
  logic [IW-1:0]                 nack_comp_r, nack_comp_nxt;
  logic [IW-1:0]                 nack_chan_r, nack_chan_nxt;
  logic                          cred_en_r, cred_en_nxt;
  logic [cfci_pkg::COUNT_W-1:0]  total_r, total_nxt;
  logic                          disc_r, disc_nxt;
  logic                          out_valid_r;
  cfci_pkg::res_t                res_r, res_nxt;
  logic                          blocked;
  logic                          word_op;
  logic                          can_add;

  // Take a request whenever the result register is free or draining
  assign req_take  = req_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign res       = res_r;

  assign blocked = nack_valid_r || disc_r;
  assign word_op = (req.op == cfci_pkg::OP_DATA) || (req.op == cfci_pkg::OP_MISROUTE)
                || (req.op == cfci_pkg::OP_CLAIM) || (req.op == cfci_pkg::OP_DISCONNECT);
  assign can_add = cred_en_r && (total_r < CAP);

  // Execute one request
  always_comb begin
    src_valid_nxt  = src_valid_r;
    src_comp_nxt   = src_comp_r;
    src_chan_nxt   = src_chan_r;
    nack_valid_nxt = nack_valid_r;
    nack_comp_nxt  = nack_comp_r;
    nack_chan_nxt  = nack_chan_r;
    cred_en_nxt    = cred_en_r;
    total_nxt      = total_r;
    disc_nxt       = disc_r;
    res_nxt        = '0;
    res_nxt.kind   = cfci_pkg::KIND_NONE;

    if (word_op && blocked) begin
      res_nxt.kind = cfci_pkg::KIND_REFUSE;
    end else begin
      case (req.op)
        cfci_pkg::OP_MISROUTE: res_nxt.kind = cfci_pkg::KIND_MISRT;
        cfci_pkg::OP_DATA: begin
          res_nxt.kind = cfci_pkg::KIND_DATA;
          res_nxt.data = req.payload;
        end
        cfci_pkg::OP_DISCONNECT: begin
          // stray disconnect without a connection is ignored
          if (src_valid_r) begin
            disc_nxt = 1'b1;
            if (can_add) total_nxt = total_r + CNT_ONE;
          end
        end
        cfci_pkg::OP_CLAIM: begin
          if (!src_valid_r) begin
            src_valid_nxt = 1'b1;
            src_comp_nxt  = req.payload[IW-1:0];
            src_chan_nxt  = req.payload[2*IW-1:IW];
            cred_en_nxt   = 1'b1;
            // credits were just enabled, so add against the cap directly
            if (total_r < CAP) total_nxt = total_r + CNT_ONE;
          end else begin
            nack_valid_nxt = 1'b1;
            nack_comp_nxt  = req.payload[IW-1:0];
            nack_chan_nxt  = req.payload[2*IW-1:IW];
          end
        end
        cfci_pkg::OP_CONSUME: begin
          if (can_add) total_nxt = total_r + CNT_ONE;
        end
        cfci_pkg::OP_SLOT: begin
          if (nack_valid_r) begin
            res_nxt.kind   = cfci_pkg::KIND_NACK;
            res_nxt.comp   = nack_comp_r;
            res_nxt.chan   = nack_chan_r;
            nack_valid_nxt = 1'b0;
            nack_comp_nxt  = '0;
            nack_chan_nxt  = '0;
          end else if (total_r != '0) begin
            res_nxt.kind  = cfci_pkg::KIND_CREDIT;
            res_nxt.comp  = src_comp_r;
            res_nxt.chan  = src_chan_r;
            res_nxt.count = total_r;
            total_nxt     = '0;
            // tear down after the final credit return
            if (disc_r) begin
              src_valid_nxt = 1'b0;
              src_comp_nxt  = '0;
              src_chan_nxt  = '0;
              cred_en_nxt   = 1'b0;
              disc_nxt      = 1'b0;
            end
          end
        end
        default: res_nxt.kind = cfci_pkg::KIND_NONE;
      endcase
    end
  end

  // Connection state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_valid_r  <= 1'b0;
      src_comp_r   <= '0;
      src_chan_r   <= '0;
      nack_valid_r <= 1'b0;
      nack_comp_r  <= '0;
      nack_chan_r  <= '0;
      cred_en_r    <= 1'b0;
      total_r      <= '0;
      disc_r       <= 1'b0;
    end else if (req_take) begin
      src_valid_r  <= src_valid_nxt;
      src_comp_r   <= src_comp_nxt;
      src_chan_r   <= src_chan_nxt;
      nack_valid_r <= nack_valid_nxt;
      nack_comp_r  <= nack_comp_nxt;
      nack_chan_r  <= nack_chan_nxt;
      cred_en_r    <= cred_en_nxt;
      total_r      <= total_nxt;
      disc_r       <= disc_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (req_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      res_r <= res_nxt;
    end
  end

endmodule
`default_nettype wire

/* hdl/credit_flow_control_input_port.sv */
// Top level of the credit flow control input port.
`timescale 1ns / 1ps
`default_nettype none
// Receiving end of a credit-flow-controlled channel. Every request (word
// arrival, downstream consume, or free credit slot) yields exactly one
// result, kind 0 included. One request is taken per cycle while in_stall
// is low: the front end decodes it against sink_id into a two-entry queue,
// and the back end then takes it from the queue head, updates the connection
// state and fills the result register that drives out_*. in_stall rises only
// while the queue is full, which happens when the result side stalls. sink_id
// is to be written through cfg_wr_en/cfg_wr_data while no request is in
// flight; the block itself does not enforce this.
module credit_flow_control_input_port #(
  parameter int MAX_CREDITS = cfci_pkg::MAX_CREDITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wr_en,
  input  wire logic [cfci_pkg::ID_W-1:0]      cfg_wr_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [cfci_pkg::CMD_W-1:0]     in_cmd,
  input  wire logic [cfci_pkg::PAYLOAD_W-1:0] in_payload,
  input  wire logic [cfci_pkg::ID_W-1:0]      in_dest_id,
  input  wire logic                           in_multicast,
  input  wire logic                           in_allocate,
  input  wire logic                           in_acquired,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [cfci_pkg::KIND_W-1:0]         out_kind,
  output logic [cfci_pkg::PAYLOAD_W-1:0]      out_data_out,
  output logic [cfci_pkg::ID_W-1:0]           out_credit_component,
  output logic [cfci_pkg::ID_W-1:0]           out_credit_channel,
  output logic [cfci_pkg::COUNT_W-1:0]        out_credit_count
);

  cfci_pkg::req_t dec_req;
  cfci_pkg::req_t head_req;
  cfci_pkg::res_t res;
  logic           q_full;
  logic           head_valid;
  logic           head_take;

  assign in_stall = q_full;

  cfci_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (in_cmd),
    .payload     (in_payload),
    .dest_id     (in_dest_id),
    .multicast   (in_multicast),
    .allocate    (in_allocate),
    .acquired    (in_acquired),
    .req         (dec_req)
  );

  cfci_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_valid),
    .push_req   (dec_req),
    .full       (q_full),
    .pop        (head_take),
    .head_valid (head_valid),
    .head_req   (head_req)
  );

  cfci_back #(
    .MAX_CREDITS (MAX_CREDITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (head_valid),
    .req       (head_req),
    .req_take  (head_take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .res       (res)
  );

  assign out_kind             = res.kind;
  assign out_data_out         = res.data;
  assign out_credit_component = res.comp;
  assign out_credit_channel   = res.chan;
  assign out_credit_count     = res.count;

endmodule
`default_nettype wire

/* hdl/cfci_checker.sv */
// Port-level checker for the credit flow control input port, with its bind.
`timescale 1ns / 1ps
`default_nettype none
module cfci_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic [cfci_pkg::KIND_W-1:0]    out_kind,
  input wire logic [cfci_pkg::PAYLOAD_W-1:0] out_data_out,
  input wire logic [cfci_pkg::ID_W-1:0]      out_credit_component,
  input wire logic [cfci_pkg::COUNT_W-1:0]   out_credit_count
);

  // Only a credit return carries a count, and it is never zero
  a_count_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_kind == cfci_pkg::KIND_CREDIT) == (out_credit_count != '0)))
    else $error("credit count does not match result kind");

  // Data is only driven on a forwarded word
  a_data_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != cfci_pkg::KIND_DATA) |-> (out_data_out == '0))
    else $error("data on a non-data result");

  // Destination only on credit or nack
  a_dest_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind != cfci_pkg::KIND_CREDIT) && (out_kind != cfci_pkg::KIND_NACK)
    |-> (out_credit_component == '0))
    else $error("credit destination on a non-credit result");

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) && $stable(out_credit_count))
    else $error("stalled result changed");

endmodule

bind credit_flow_control_input_port cfci_checker u_cfci_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_kind             (out_kind),
  .out_data_out         (out_data_out),
  .out_credit_component (out_credit_component),
  .out_credit_count     (out_credit_count)
);
`default_nettype wire
